// ===== design/gdad_pkg.sv =====
// ----------------------------------------------------------------------------
// gdad_pkg: shared definitions for the Gregorian date adder
// Codes, reset values, calendar helpers and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gdad_pkg;

  // Default widths of the year and day delta fields.
  localparam int YEAR_BITS_DEF  = 16;
  localparam int DELTA_BITS_DEF = 20;

  // Fixed field widths.
  localparam int KIND_BITS     = 2;
  localparam int MONTH_BITS    = 4;
  localparam int LOAD_DAY_BITS = 6;
  localparam int DAY_BITS      = 5;
  localparam int STATUS_BITS   = 3;
  localparam int CFG_ADDR_BITS = 2;
  localparam int MOD25_BITS    = 5;

  // Request kinds.
  localparam logic [KIND_BITS-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_MOVE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_PEEK = 2'd2;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_MONTH_LOW  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_MONTH_HIGH = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_DAY_LOW    = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_DAY_HIGH   = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_YEAR_LOW   = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_YEAR_HIGH  = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] REG_DEF_YEAR  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DEF_MONTH = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DEF_DAY   = 2'd2;

  // Reset date.
  localparam int RESET_YEAR  = 1970;
  localparam int RESET_MONTH = 1;
  localparam int RESET_DAY   = 1;

  // Calendar constants.
  localparam int MOD_BASE  = 25;
  localparam int MONTH_MAX = 12;
  localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

  // Leap year from the low four bits of the year and the year modulo 25.
  // A year is a leap year when divisible by 4, unless divisible by 100
  // (by 4 and by 25) without being divisible by 400 (by 16 and by 25).
  function automatic logic is_leap(input logic [3:0] y_low,
                                   input logic [MOD25_BITS-1:0] y_mod25);
    return (y_low[1:0] == 2'd0) && ((y_mod25 != '0) || (y_low == 4'd0));
  endfunction

  // Length of a month; codes outside 1 to 12 read as 31.
  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                    input logic leap);
    logic [DAY_BITS-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the accepted request into the datapath
    logic mod_start;  // start the residue unit on the load and default years
    logic walk_init;  // set up the month walk from the stored date
    logic walk_step;  // advance the month walk by one month
    logic commit;     // write the result and update the stored date
  } gdad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_BITS-1:0] kind;  // kind of the captured request
    logic mod_busy;              // residue unit still working
    logic walk_stop;             // month walk has settled or hit a year limit
    logic out_free;              // result register can take a new result
  } gdad_sts_t;

endpackage

// ===== design/gdad_mod25.sv =====
// ----------------------------------------------------------------------------
// gdad_mod25: residue unit for the leap-year rule
// Reduces two words modulo 25 in parallel, registering the quotient found
// by a reciprocal multiplication and then the remainder.
// ----------------------------------------------------------------------------
module gdad_mod25 #(
  parameter int WIDTH = gdad_pkg::YEAR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [WIDTH-1:0]                 a,
  input  logic [WIDTH-1:0]                 b,
  output logic                             busy,
  output logic [gdad_pkg::MOD25_BITS-1:0]  res_a,
  output logic [gdad_pkg::MOD25_BITS-1:0]  res_b
);

  // With SHIFT = WIDTH + 5 and RECIP the reciprocal of 25 rounded up,
  // (x * RECIP) >> SHIFT is the exact quotient for every x below 2**WIDTH.
  localparam int     SHIFT      = WIDTH + 5;
  localparam int     RECIP_BITS = WIDTH + 1;
  localparam int     PROD_BITS  = WIDTH + RECIP_BITS;
  localparam int     QUOT_BITS  = PROD_BITS - SHIFT;
  localparam longint BASE_L     = longint'(gdad_pkg::MOD_BASE);
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((longint'(1) << SHIFT) + BASE_L - 1) / BASE_L);

  logic                 pend;
  logic [WIDTH-1:0]     op_a;
  logic [WIDTH-1:0]     op_b;
  logic [QUOT_BITS-1:0] quo_a;
  logic [QUOT_BITS-1:0] quo_b;
  logic [PROD_BITS-1:0] prod_a;
  logic [PROD_BITS-1:0] prod_b;
  logic [WIDTH-1:0]     mul_a;
  logic [WIDTH-1:0]     mul_b;
  logic [WIDTH-1:0]     rem_a;
  logic [WIDTH-1:0]     rem_b;

  assign prod_a = PROD_BITS'(a) * PROD_BITS'(RECIP);
  assign prod_b = PROD_BITS'(b) * PROD_BITS'(RECIP);

  // The quotient times 25 is built from shifts, as 16q + 8q + q.
  assign mul_a = (WIDTH'(quo_a) << 4) + (WIDTH'(quo_a) << 3) + WIDTH'(quo_a);
  assign mul_b = (WIDTH'(quo_b) << 4) + (WIDTH'(quo_b) << 3) + WIDTH'(quo_b);
  assign rem_a = op_a - mul_a;
  assign rem_b = op_b - mul_b;

  assign busy = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (start) begin
      pend <= 1'b1;
    end else begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_a  <= a;
      op_b  <= b;
      quo_a <= prod_a[PROD_BITS-1:SHIFT];
      quo_b <= prod_b[PROD_BITS-1:SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      res_a <= gdad_pkg::MOD25_BITS'(rem_a);
      res_b <= gdad_pkg::MOD25_BITS'(rem_b);
    end
  end

endmodule

// ===== design/gdad_datapath.sv =====
// ----------------------------------------------------------------------------
// gdad_datapath: date registers, month walk and result register
// Holds the configuration, the stored date and its residue, the captured
// request, the month walk registers and the output register.
// ----------------------------------------------------------------------------
module gdad_datapath #(
  parameter int YEAR_BITS  = gdad_pkg::YEAR_BITS_DEF,
  parameter int DELTA_BITS = gdad_pkg::DELTA_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gdad_pkg::gdad_cmd_t                 cmd,
  output gdad_pkg::gdad_sts_t                 sts,
  // configuration
  input  logic                                cfg_we,
  input  logic [gdad_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [YEAR_BITS-1:0]                cfg_data,
  // request fields
  input  logic [gdad_pkg::KIND_BITS-1:0]      in_kind,
  input  logic [YEAR_BITS-1:0]                in_load_year,
  input  logic [gdad_pkg::MONTH_BITS-1:0]     in_load_month,
  input  logic [gdad_pkg::LOAD_DAY_BITS-1:0]  in_load_day,
  input  logic [DELTA_BITS-1:0]               in_day_delta,
  // result
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [YEAR_BITS-1:0]                out_year,
  output logic [gdad_pkg::MONTH_BITS-1:0]     out_month,
  output logic [gdad_pkg::DAY_BITS-1:0]       out_day,
  output logic [gdad_pkg::STATUS_BITS-1:0]    out_status
);

  localparam int MB = gdad_pkg::MONTH_BITS;
  localparam int DB = gdad_pkg::DAY_BITS;
  localparam int RB = gdad_pkg::MOD25_BITS;
  localparam int TB = DELTA_BITS + 1;
  localparam logic [MB-1:0] MONTH_TOP = MB'(gdad_pkg::MONTH_MAX);
  localparam logic [RB-1:0] MOD_TOP   = RB'(gdad_pkg::MOD_BASE - 1);

  // Configuration registers.
  logic [YEAR_BITS-1:0] def_year;
  logic [MB-1:0]        def_month;
  logic [DB-1:0]        def_day;

  // Stored date and its year modulo 25.
  logic [YEAR_BITS-1:0] cur_year;
  logic [MB-1:0]        cur_month;
  logic [DB-1:0]        cur_day;
  logic [RB-1:0]        cur_mod;

  // Captured request.
  logic [gdad_pkg::KIND_BITS-1:0]     req_kind;
  logic [YEAR_BITS-1:0]               ld_year;
  logic [MB-1:0]                      ld_month;
  logic [gdad_pkg::LOAD_DAY_BITS-1:0] ld_day;
  logic [DELTA_BITS-1:0]              delta;

  // Month walk: date of the first of the current month and the day offset.
  logic [YEAR_BITS-1:0] wy;
  logic [MB-1:0]        wm;
  logic [RB-1:0]        wmod;
  logic [TB-1:0]        t;

  logic          mod_busy;
  logic [RB-1:0] mod_ld;
  logic [RB-1:0] mod_def;

  gdad_mod25 #(
    .WIDTH (YEAR_BITS)
  ) u_mod25 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mod_start),
    .a     (ld_year),
    .b     (def_year),
    .busy  (mod_busy),
    .res_a (mod_ld),
    .res_b (mod_def)
  );

  // ---- Month walk step ----
  logic                             leap_w;
  logic [DB-1:0]                    len_cur;
  logic [DB-1:0]                    len_prev;
  logic [MB-1:0]                    prev_m;
  logic                             t_neg;
  logic                             t_high;
  logic                             at_min;
  logic                             at_max;
  logic [gdad_pkg::STATUS_BITS-1:0] walk_err;
  logic                             walk_stop;

  assign leap_w   = gdad_pkg::is_leap(wy[3:0], wmod);
  assign len_cur  = gdad_pkg::month_len(wm, leap_w);
  assign prev_m   = (wm == gdad_pkg::MONTH_JAN) ? gdad_pkg::MONTH_DEC : wm - 1'b1;
  assign len_prev = gdad_pkg::month_len(prev_m, leap_w);
  assign t_neg    = t[TB-1];
  assign t_high   = !t_neg && (t >= TB'(len_cur));
  assign at_min   = (wy == '0) && (wm == gdad_pkg::MONTH_JAN);
  assign at_max   = (wy == '1) && (wm == gdad_pkg::MONTH_DEC);

  always_comb begin
    if (t_neg && at_min) begin
      walk_err = gdad_pkg::ST_YEAR_LOW;
    end else if (t_high && at_max) begin
      walk_err = gdad_pkg::ST_YEAR_HIGH;
    end else begin
      walk_err = gdad_pkg::ST_OK;
    end
  end

  assign walk_stop = !(t_neg || t_high) || (walk_err != gdad_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      wy   <= cur_year;
      wm   <= cur_month;
      wmod <= cur_mod;
      t    <= {{(TB-DELTA_BITS){delta[DELTA_BITS-1]}}, delta} + TB'(cur_day - 1'b1);
    end else if (cmd.walk_step && !walk_stop) begin
      if (t_neg) begin
        t  <= t + TB'(len_prev);
        wm <= prev_m;
        if (wm == gdad_pkg::MONTH_JAN) begin
          wy   <= wy - 1'b1;
          wmod <= (wmod == '0) ? MOD_TOP : wmod - 1'b1;
        end
      end else begin
        t  <= t - TB'(len_cur);
        wm <= (wm == gdad_pkg::MONTH_DEC) ? gdad_pkg::MONTH_JAN : wm + 1'b1;
        if (wm == gdad_pkg::MONTH_DEC) begin
          wy   <= wy + 1'b1;
          wmod <= (wmod == MOD_TOP) ? '0 : wmod + 1'b1;
        end
      end
    end
  end

  // ---- Load check and default date ----
  logic [DB-1:0]                    ld_len;
  logic [gdad_pkg::STATUS_BITS-1:0] ld_status;
  logic [MB-1:0]                    dm;
  logic [DB-1:0]                    dlen;
  logic [DB-1:0]                    dd;

  assign ld_len = gdad_pkg::month_len(ld_month, gdad_pkg::is_leap(ld_year[3:0], mod_ld));

  always_comb begin
    if (ld_month == '0) begin
      ld_status = gdad_pkg::ST_MONTH_LOW;
    end else if (ld_month > MONTH_TOP) begin
      ld_status = gdad_pkg::ST_MONTH_HIGH;
    end else if (ld_day == '0) begin
      ld_status = gdad_pkg::ST_DAY_LOW;
    end else if (ld_day > gdad_pkg::LOAD_DAY_BITS'(ld_len)) begin
      ld_status = gdad_pkg::ST_DAY_HIGH;
    end else begin
      ld_status = gdad_pkg::ST_OK;
    end
  end

  // The default registers may hold an illegal date: clamp month, then day.
  always_comb begin
    if (def_month == '0) begin
      dm = gdad_pkg::MONTH_JAN;
    end else if (def_month > MONTH_TOP) begin
      dm = gdad_pkg::MONTH_DEC;
    end else begin
      dm = def_month;
    end
    dlen = gdad_pkg::month_len(dm, gdad_pkg::is_leap(def_year[3:0], mod_def));
    if (def_day == '0) begin
      dd = DB'(1);
    end else if (def_day > dlen) begin
      dd = dlen;
    end else begin
      dd = def_day;
    end
  end

  // ---- Result selection ----
  logic [YEAR_BITS-1:0]             res_year;
  logic [MB-1:0]                    res_month;
  logic [DB-1:0]                    res_day;
  logic [gdad_pkg::STATUS_BITS-1:0] res_status;
  logic [RB-1:0]                    res_mod;
  logic                             res_store;

  always_comb begin
    res_year   = cur_year;
    res_month  = cur_month;
    res_day    = cur_day;
    res_status = gdad_pkg::ST_OK;
    res_mod    = cur_mod;
    res_store  = 1'b0;
    case (req_kind)
      gdad_pkg::KIND_LOAD: begin
        res_status = ld_status;
        res_store  = 1'b1;
        if (ld_status == gdad_pkg::ST_OK) begin
          res_year  = ld_year;
          res_month = ld_month;
          res_day   = DB'(ld_day);
          res_mod   = mod_ld;
        end else begin
          res_year  = def_year;
          res_month = dm;
          res_day   = dd;
          res_mod   = mod_def;
        end
      end
      gdad_pkg::KIND_MOVE,
      gdad_pkg::KIND_PEEK: begin
        res_status = walk_err;
        if (walk_err == gdad_pkg::ST_OK) begin
          res_year  = wy;
          res_month = wm;
          res_day   = t[DB-1:0] + 1'b1;
          res_mod   = wmod;
          res_store = (req_kind == gdad_pkg::KIND_MOVE);
        end
      end
      default: begin
        res_status = gdad_pkg::ST_OK;
      end
    endcase
  end

  // ---- Registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      def_year  <= YEAR_BITS'(gdad_pkg::RESET_YEAR);
      def_month <= MB'(gdad_pkg::RESET_MONTH);
      def_day   <= DB'(gdad_pkg::RESET_DAY);
    end else if (cfg_we) begin
      case (cfg_addr)
        gdad_pkg::REG_DEF_YEAR:  def_year  <= cfg_data;
        gdad_pkg::REG_DEF_MONTH: def_month <= cfg_data[MB-1:0];
        gdad_pkg::REG_DEF_DAY:   def_day   <= cfg_data[DB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year  <= YEAR_BITS'(gdad_pkg::RESET_YEAR);
      cur_month <= MB'(gdad_pkg::RESET_MONTH);
      cur_day   <= DB'(gdad_pkg::RESET_DAY);
      cur_mod   <= RB'(gdad_pkg::RESET_YEAR % gdad_pkg::MOD_BASE);
    end else if (cmd.commit && res_store) begin
      cur_year  <= res_year;
      cur_month <= res_month;
      cur_day   <= res_day;
      cur_mod   <= res_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind <= in_kind;
      ld_year  <= in_load_year;
      ld_month <= in_load_month;
      ld_day   <= in_load_day;
      delta    <= in_day_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_year   <= res_year;
      out_month  <= res_month;
      out_day    <= res_day;
      out_status <= res_status;
    end
  end

  assign sts.kind      = req_kind;
  assign sts.mod_busy  = mod_busy;
  assign sts.walk_stop = walk_stop;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ===== design/gdad_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdad_ctrl: request sequencer
// Accepts one request at a time and steps the datapath through the load
// check or the month walk, then hands the result to the output register.
// ----------------------------------------------------------------------------
module gdad_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gdad_pkg::gdad_sts_t  sts,
  output gdad_pkg::gdad_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_MODW   = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        case (sts.kind)
          gdad_pkg::KIND_LOAD: begin
            cmd.mod_start = 1'b1;
            state_next    = S_MODW;
          end
          gdad_pkg::KIND_MOVE,
          gdad_pkg::KIND_PEEK: begin
            cmd.walk_init = 1'b1;
            state_next    = S_WALK;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_MODW: begin
        if (!sts.mod_busy) begin
          state_next = S_FINISH;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_stop) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/gregorian_date_add_days.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days: Gregorian date register with day arithmetic
// Holds one date, loads and checks dates, and moves or peeks the date by a
// signed number of days, one month at a time.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream channel: tuser carries the kind (load,
// move or peek) and tdata the load date and the day delta. Every request
// gives exactly one result on the m_ stream channel: the date and a status.
// A load first reduces the loaded year and the default year modulo 25 for
// the leap-year rule, by a reciprocal multiplication whose quotient and
// remainder are registered in turn. A move or peek walks the date one
// calendar month per cycle, until the day offset falls within the month or
// a year limit is hit. The month walk bounds the rate.
// Only one request is in flight: s_tready is high while the sequencer is
// idle, from the cycle after a result is written. The result sits in an
// output register; a stalled receiver holds it, and a new request may then
// be accepted and worked on, but its result waits until the register has
// been emptied. Reset clears the configuration to 1970-01-01 and stores
// that date. Write the configuration only while no request is in flight.
// ----------------------------------------------------------------------------
module gregorian_date_add_days #(
  parameter int YEAR_BITS  = gdad_pkg::YEAR_BITS_DEF,
  parameter int DELTA_BITS = gdad_pkg::DELTA_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [gdad_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [YEAR_BITS-1:0]                cfg_data,
  // request channel
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tdata, lowest bit first: load_year, load_month, load_day, day_delta, zero fill
  input  logic [((YEAR_BITS + DELTA_BITS + 10 + 7) / 8) * 8 - 1:0] s_tdata,
  // tuser: kind
  input  logic [gdad_pkg::KIND_BITS-1:0]      s_tuser,
  // result channel
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tdata, lowest bit first: out_year, out_month, out_day, status, zero fill
  output logic [((YEAR_BITS + 12 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int MB  = gdad_pkg::MONTH_BITS;
  localparam int LDB = gdad_pkg::LOAD_DAY_BITS;
  localparam int DB  = gdad_pkg::DAY_BITS;
  localparam int SB  = gdad_pkg::STATUS_BITS;
  localparam int RES_BITS = YEAR_BITS + MB + DB + SB;

  gdad_pkg::gdad_cmd_t cmd;
  gdad_pkg::gdad_sts_t sts;

  logic [YEAR_BITS-1:0] out_year;
  logic [MB-1:0]        out_month;
  logic [DB-1:0]        out_day;
  logic [SB-1:0]        out_status;

  // The sequencer decides which datapath operation runs in each cycle.
  gdad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Request fields are unpacked from tdata in order from the lowest bit.
  gdad_datapath #(
    .YEAR_BITS  (YEAR_BITS),
    .DELTA_BITS (DELTA_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .in_kind       (s_tuser),
    .in_load_year  (s_tdata[YEAR_BITS-1:0]),
    .in_load_month (s_tdata[YEAR_BITS+MB-1:YEAR_BITS]),
    .in_load_day   (s_tdata[YEAR_BITS+MB+LDB-1:YEAR_BITS+MB]),
    .in_day_delta  (s_tdata[YEAR_BITS+MB+LDB+DELTA_BITS-1:YEAR_BITS+MB+LDB]),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_year      (out_year),
    .out_month     (out_month),
    .out_day       (out_day),
    .out_status    (out_status)
  );

  // The result fields are packed from the lowest bit, with zero fill above.
  always_comb begin
    m_tdata                 = '0;
    m_tdata[RES_BITS-1:0]   = {out_status, out_day, out_month, out_year};
  end

endmodule

// ===== sim/gregorian_date_add_days_tb.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days_tb: self-checking bench for the Gregorian date adder
// The bench drives load, move, peek and spare requests into the block. It
// predicts each result from its own calendar model that works on day numbers,
// and compares every returned date and status, field by field, in order.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_tb;
  import gdad_pkg::*;

  // Widths as the block is built with its default parameters.
  localparam int YEAR_W = YEAR_BITS_DEF;
  localparam int DELTA_W = DELTA_BITS_DEF;
  localparam int IN_W = ((YEAR_W + DELTA_W + 10 + 7) / 8) * 8;
  localparam int OUT_W = ((YEAR_W + 12 + 7) / 8) * 8;
  localparam longint YEAR_TOP = (longint'(1) << YEAR_W) - 1;

  // Bit positions of the result fields in m_tdata, lowest field first.
  localparam int OUT_MONTH_LSB = YEAR_W;
  localparam int OUT_DAY_LSB = OUT_MONTH_LSB + MONTH_BITS;
  localparam int OUT_STATUS_LSB = OUT_DAY_LSB + DAY_BITS;

  // The kind code that the block does not use.
  localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;

  localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W - 1){1'b1}}};
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W - 1){1'b0}}};

  // Day numbers are taken with the year moved up by 400 so that every
  // intermediate quantity stays positive and division truncates safely.
  localparam longint EPOCH_SHIFT = 400;

  localparam int ITEM_TARGET = 1850;
  localparam int IDLE_PCT = 11;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PAUSE = 8;
  localparam int TAIL_CYCLES = 64;
  localparam int MAX_REPORTS = 100;
  // A full-range move walks some 17300 months, one per cycle; the limit on
  // cycles without any handshake leaves a wide margin above that.
  localparam int WATCHDOG_LIMIT = 60000;

  typedef struct {
    logic [YEAR_W-1:0]      year;
    logic [MONTH_BITS-1:0]  month;
    logic [DAY_BITS-1:0]    day;
    logic [STATUS_BITS-1:0] status;
  } date_res_t;

  // Every input of the block holds a known value from time zero.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [YEAR_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [KIND_BITS-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // Our own copy of the configuration and of the stored date.
  logic [YEAR_W-1:0]     dflt_year = YEAR_W'(RESET_YEAR);
  logic [MONTH_BITS-1:0] dflt_month = MONTH_BITS'(RESET_MONTH);
  logic [DAY_BITS-1:0]   dflt_day = DAY_BITS'(RESET_DAY);
  logic [YEAR_W-1:0]     held_year = YEAR_W'(RESET_YEAR);
  logic [MONTH_BITS-1:0] held_month = MONTH_BITS'(RESET_MONTH);
  logic [DAY_BITS-1:0]   held_day = DAY_BITS'(RESET_DAY);

  // Results still owed by the block, oldest first.
  date_res_t dates_due[$];
  date_res_t due;

  int sent_count = 0;
  int result_count = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int hold_cnt = 0;
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;

  gregorian_date_add_days u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calendar model
  // --------------------------------------------------------------------------

  // Proleptic Gregorian rule: year 0 counts as a leap year.
  function automatic bit is_leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(input longint y, input int m);
    case (m)
      2: return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Day number of a legal date, counted in 400-year eras with the year
  // starting in March so that the leap day falls at the end of the year.
  function automatic longint epoch_day(input longint y, input int m, input int d);
    longint yy, era, yoe, mp, doy, doe;
    yy = y + EPOCH_SHIFT - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp = (m + 9) % 12;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe;
  endfunction

  // Inverse of epoch_day for a non-negative day number; the year comes back
  // unshifted and may therefore be negative.
  function automatic void date_of_day(input longint z, output longint y,
                                      output int m, output int d);
    longint era, doe, yoe, doy, mp;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    m = int'((mp < 10) ? mp + 3 : mp - 9);
    d = int'(doy - (153 * mp + 2) / 5 + 1);
    y = yoe + era * 400 + ((m <= 2) ? 1 : 0) - EPOCH_SHIFT;
  endfunction

  // The default registers may hold an impossible date, so the month is
  // clamped first and the day then clamped to the length of that month.
  function automatic void restore_default_date();
    int mo, dy;
    mo = dflt_month;
    dy = dflt_day;
    if (mo < 1) mo = 1;
    if (mo > MONTH_MAX) mo = MONTH_MAX;
    if (dy < 1) dy = 1;
    if (dy > month_days(dflt_year, mo)) dy = month_days(dflt_year, mo);
    held_year = dflt_year;
    held_month = MONTH_BITS'(mo);
    held_day = DAY_BITS'(dy);
  endfunction

  // Works out the result of one accepted request and updates the stored date.
  function automatic date_res_t advance_date(input logic [KIND_BITS-1:0] kind,
                                             input logic [YEAR_W-1:0] year,
                                             input logic [MONTH_BITS-1:0] month,
                                             input logic [LOAD_DAY_BITS-1:0] day,
                                             input logic signed [DELTA_W-1:0] delta);
    date_res_t res;
    longint z, ny;
    int nm, nd;
    bit fresh;
    res.status = ST_OK;
    fresh = 1'b0;
    if (kind == KIND_LOAD) begin
      // The first failing check decides the status.
      if (month < 1) res.status = ST_MONTH_LOW;
      else if (month > MONTH_MAX) res.status = ST_MONTH_HIGH;
      else if (day < 1) res.status = ST_DAY_LOW;
      else if (day > month_days(year, month)) res.status = ST_DAY_HIGH;
      if (res.status == ST_OK) begin
        held_year = year;
        held_month = month;
        held_day = day[DAY_BITS-1:0];
      end else begin
        restore_default_date();
      end
    end else if (kind == KIND_MOVE || kind == KIND_PEEK) begin
      z = epoch_day(held_year, held_month, held_day) + longint'(delta);
      if (z < epoch_day(0, 1, 1)) begin
        res.status = ST_YEAR_LOW;
      end else begin
        date_of_day(z, ny, nm, nd);
        if (ny < 0) begin
          res.status = ST_YEAR_LOW;
        end else if (ny > YEAR_TOP) begin
          res.status = ST_YEAR_HIGH;
        end else begin
          fresh = 1'b1;
          res.year = ny[YEAR_W-1:0];
          res.month = MONTH_BITS'(nm);
          res.day = DAY_BITS'(nd);
          // Only a move keeps the new date; a peek leaves the store alone.
          if (kind == KIND_MOVE) begin
            held_year = res.year;
            held_month = res.month;
            held_day = res.day;
          end
        end
      end
    end
    // Loads, failed moves and peeks, and the spare kind all return the stored date.
    if (!fresh) begin
      res.year = held_year;
      res.month = held_month;
      res.day = held_day;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Years are biased towards the leap-year corner cases and the range ends.
  function automatic logic [YEAR_W-1:0] pick_year();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(2400, 1600);
      4: return $urandom_range(655) * 100;
      5: return $urandom_range(3);
      6: return YEAR_TOP - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // Mostly short hops; wide ones are rare because the walk steps through
  // every month crossed.
  function automatic logic signed [DELTA_W-1:0] pick_delta();
    int pct;
    pct = $urandom_range(99);
    if (pct < 55) return int'($urandom_range(80)) - 40;
    if (pct < 84) return int'($urandom_range(3000)) - 1500;
    if (pct < 99) return int'($urandom_range(80000)) - 40000;
    return $urandom;
  endfunction

  // Offers one request and waits for it to be taken. The prediction is made
  // at the acceptance edge, so it sees exactly the state the block sees.
  task automatic send_request(input logic [KIND_BITS-1:0] kind,
                              input logic [YEAR_W-1:0] year,
                              input logic [MONTH_BITS-1:0] month,
                              input logic [LOAD_DAY_BITS-1:0] day,
                              input logic signed [DELTA_W-1:0] delta);
    while (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {delta, day, month, year};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    dates_due.push_back(advance_date(kind, year, month, day, delta));
    sent_count++;
  endtask

  // Lets the block drain completely; the configuration may only change then.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (dates_due.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Writes all three default registers on consecutive edges.
  task automatic write_defaults(input logic [YEAR_W-1:0] year,
                                input logic [YEAR_W-1:0] month,
                                input logic [YEAR_W-1:0] day);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= REG_DEF_YEAR;
    cfg_data <= year;
    @(posedge clk);
    cfg_addr <= REG_DEF_MONTH;
    cfg_data <= month;
    @(posedge clk);
    cfg_addr <= REG_DEF_DAY;
    cfg_data <= day;
    @(posedge clk);
    cfg_we <= 1'b0;
    dflt_year = year;
    dflt_month = month[MONTH_BITS-1:0];
    dflt_day = day[DAY_BITS-1:0];
  endtask

  // Most traffic is a legal load followed by a run of moves and peeks, as
  // real use would look; the rest is noise with any of the four kinds and
  // any fields, so the loads among it are mostly illegal.
  task automatic random_sequence();
    logic [YEAR_W-1:0] y;
    logic [MONTH_BITS-1:0] m;
    int len;
    if ($urandom_range(99) < 80) begin
      y = pick_year();
      m = $urandom_range(MONTH_MAX, 1);
      len = month_days(y, m);
      send_request(KIND_LOAD, y, m,
                   ($urandom_range(99) < 25) ? len : $urandom_range(len, 1), $urandom);
      repeat ($urandom_range(8, 2)) begin
        send_request(($urandom_range(99) < 60) ? KIND_MOVE : KIND_PEEK,
                     $urandom, $urandom, $urandom, pick_delta());
      end
    end else begin
      send_request($urandom_range(3), $urandom, $urandom, $urandom, pick_delta());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight after reset the store must read 1970-01-01, whether through the
  // spare kind or through a peek by zero days.
  task automatic test_reset_date();
    send_request(KIND_SPARE, $urandom, $urandom, $urandom, $urandom);
    send_request(KIND_PEEK, $urandom, $urandom, $urandom, 0);
  endtask

  // Each load check in turn, plus the century rule for the leap day.
  task automatic test_load_checks();
    send_request(KIND_LOAD, 2000, MONTH_FEB, 29, $urandom);
    send_request(KIND_LOAD, 1900, MONTH_FEB, 29, $urandom);
    send_request(KIND_LOAD, 0, MONTH_FEB, 29, $urandom);
    send_request(KIND_LOAD, 2024, 0, 0, $urandom);
    send_request(KIND_LOAD, 2024, 15, 1, $urandom);
    send_request(KIND_LOAD, 2024, 6, 0, $urandom);
    send_request(KIND_LOAD, 2024, MONTH_JAN, 63, $urandom);
    send_request(KIND_LOAD, 2023, 4, 31, $urandom);
  endtask

  // Crossing the year boundary both ways and a peek over a leap year.
  task automatic test_month_walk();
    send_request(KIND_LOAD, 1999, MONTH_DEC, 31, $urandom);
    send_request(KIND_MOVE, $urandom, $urandom, $urandom, 1);
    send_request(KIND_MOVE, $urandom, $urandom, $urandom, -60);
    send_request(KIND_PEEK, $urandom, $urandom, $urandom, 366);
  endtask

  // Both ends of the year range, and the widest deltas either way.
  task automatic test_year_limits();
    send_request(KIND_LOAD, 0, MONTH_JAN, 1, $urandom);
    send_request(KIND_MOVE, $urandom, $urandom, $urandom, -1);
    send_request(KIND_PEEK, $urandom, $urandom, $urandom, DELTA_MIN);
    send_request(KIND_LOAD, YEAR_TOP, MONTH_DEC, 31, $urandom);
    send_request(KIND_MOVE, $urandom, $urandom, $urandom, 1);
    send_request(KIND_PEEK, $urandom, $urandom, $urandom, DELTA_MAX);
    send_request(KIND_MOVE, $urandom, $urandom, $urandom, DELTA_MIN);
    send_request(KIND_MOVE, $urandom, $urandom, $urandom, DELTA_MAX);
  endtask

  // Extreme and impossible defaults, then a few random settings with junk
  // in the upper data bits. Each setting is reached through illegal loads.
  task automatic test_default_registers();
    logic [YEAR_W-1:0] set_year[4] = '{0, YEAR_TOP, 2000, 1900};
    logic [YEAR_W-1:0] set_month[4] = '{0, 15, 2, 2};
    logic [YEAR_W-1:0] set_day[4] = '{0, 31, 31, 30};
    for (int i = 0; i < 7; i++) begin
      if (i < 4) begin
        write_defaults(set_year[i], set_month[i], set_day[i]);
      end else begin
        write_defaults($urandom, $urandom, $urandom);
      end
      send_request(KIND_LOAD, $urandom, 0, $urandom, $urandom);
      send_request(KIND_PEEK, $urandom, $urandom, $urandom, -1);
      send_request(KIND_LOAD, $urandom, MONTH_FEB, 0, $urandom);
      send_request(KIND_MOVE, $urandom, $urandom, $urandom, 1);
    end
  endtask

  // The receiver stops for a long while and the sender keeps offering, so
  // the result register fills and the block has to stall its input.
  task automatic test_receiver_hold();
    wait_idle();
    hold_cnt <= HOLD_CYCLES;
    repeat (3) random_sequence();
  endtask

  // A long stretch with both sides always ready.
  task automatic test_unbroken_stream();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    repeat (25) random_sequence();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // The bulk of the run, with a fresh default date every few hundred
  // requests.
  task automatic test_random_traffic();
    int next_cfg;
    next_cfg = sent_count + 300;
    while (sent_count < ITEM_TARGET) begin
      if (sent_count >= next_cfg) begin
        write_defaults(pick_year(), $urandom, $urandom);
        next_cfg = sent_count + 300;
      end
      random_sequence();
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("ERROR result %0d: %s is %0d, expected %0d", result_count, what, got, want);
    end
  endtask

  // The hold-off is counted down in its own process.
  always @(posedge clk) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // Receiver: takes results, compares them with the oldest prediction and
  // drops tready at random or for the whole of a hold-off.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (dates_due.size() == 0) begin
        report_mismatch("result with no request owed, data", m_tdata, 0);
      end else begin
        due = dates_due.pop_front();
        if (m_tdata[YEAR_W-1:0] !== due.year)
          report_mismatch("year", m_tdata[YEAR_W-1:0], due.year);
        if (m_tdata[OUT_MONTH_LSB +: MONTH_BITS] !== due.month)
          report_mismatch("month", m_tdata[OUT_MONTH_LSB +: MONTH_BITS], due.month);
        if (m_tdata[OUT_DAY_LSB +: DAY_BITS] !== due.day)
          report_mismatch("day", m_tdata[OUT_DAY_LSB +: DAY_BITS], due.day);
        if (m_tdata[OUT_STATUS_LSB +: STATUS_BITS] !== due.status)
          report_mismatch("status", m_tdata[OUT_STATUS_LSB +: STATUS_BITS], due.status);
      end
    end
    m_tready <= (hold_cnt == 0) && !(rx_stalls && $urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: a block that stops taking requests or giving results ends the
  // run once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("ERROR no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_date();
    test_load_checks();
    test_month_walk();
    test_year_limits();
    test_default_registers();
    test_receiver_hold();
    test_unbroken_stream();
    test_random_traffic();
    // Drain, then give the block time to show any stray result.
    s_tvalid <= 1'b0;
    while (dates_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
